// File: sv/apt_pkg.sv
// Shared widths, register codes, constants and types of the affine point transform.
`timescale 1ns / 1ps

package apt_pkg;

  // Field and datapath widths.
  localparam int COORD_W = 64;
  localparam int ADDR_W  = 6;
  localparam int IDX_W   = 3;
  localparam int NUM_W   = 192;
  localparam int DEN_W   = 128;
  localparam int QUO_W   = 64;

  // Pipeline depth: six front stages, then the divider.
  localparam int FRONT_LAT = 6;
  localparam int DIV_LAT   = QUO_W + 3;
  localparam int TOTAL     = FRONT_LAT + DIV_LAT;

  // Register indexes, byte address 8*index.
  localparam logic [IDX_W-1:0] REG_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_B = 3'd1;
  localparam logic [IDX_W-1:0] REG_C = 3'd2;
  localparam logic [IDX_W-1:0] REG_D = 3'd3;
  localparam logic [IDX_W-1:0] REG_E = 3'd4;
  localparam logic [IDX_W-1:0] REG_F = 3'd5;

  // Transfer kinds.
  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_REV = 1'b1;

  // Fixed-point constants.
  localparam logic [COORD_W-1:0] ONE_Q   = 64'h0000_0001_0000_0000;
  localparam logic [COORD_W-1:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [COORD_W-1:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [DEN_W-1:0]   DEN_FWD = 128'h1_0000_0000;

  // Per-item data that rides alongside the arithmetic.
  typedef struct packed {
    logic                      kind;
    logic                      deg;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } side_t;

endpackage

// File: sv/apt_if.sv
// Point and result channel interfaces of the affine point transform.
`timescale 1ns / 1ps

interface apt_in_if import apt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  modport source (output valid, kind, point_x, point_y, input ready);
  modport sink (input valid, kind, point_x, point_y, output ready);
endinterface

interface apt_out_if import apt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] result_x;
  logic signed [COORD_W-1:0] result_y;
  logic                      degenerate;
  modport source (output valid, result_x, result_y, degenerate, input ready);
  modport sink (input valid, result_x, result_y, degenerate, output ready);
endinterface

// File: sv/apt_div.sv
// Pipelined restoring divider with round-half-away and signed saturation.
`timescale 1ns / 1ps

module apt_div import apt_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  input  logic               neg,
  output logic [COORD_W-1:0] quo
);

  logic [NUM_W-1:0] rem [QUO_W+1];
  logic [QUO_W-1:0] qt  [QUO_W+1];
  logic [DEN_W-1:0] dv  [QUO_W+1];
  logic             ng  [QUO_W+1];
  logic             of  [QUO_W+1];

  logic [QUO_W:0]   qr;
  logic             ng_r;
  logic             of_r;

  // Entry stage: a quotient of 2^64 or more saturates.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      qt[0]  <= '0;
      dv[0]  <= den;
      ng[0]  <= neg;
      of[0]  <= num >= {den, {QUO_W{1'b0}}};
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    localparam int K = QUO_W - 1 - g;
    logic [NUM_W-1:0] dsh;
    logic             ge;
    assign dsh = NUM_W'(dv[g]) << K;
    assign ge  = rem[g] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= ge ? rem[g] - dsh : rem[g];
        qt[g+1]  <= qt[g] | (QUO_W'(ge) << K);
        dv[g+1]  <= dv[g];
        ng[g+1]  <= ng[g];
        of[g+1]  <= of[g];
      end
    end
  end

  // Round to nearest; the remainder is below the divisor here unless the quotient overflowed.
  always_ff @(posedge clk) begin
    if (en) begin
      qr   <= {1'b0, qt[QUO_W]} +
              (QUO_W+1)'({rem[QUO_W][DEN_W-1:0], 1'b0} >= {1'b0, dv[QUO_W]});
      ng_r <= ng[QUO_W];
      of_r <= of[QUO_W];
    end
  end

  // Apply the sign and clamp to the 64-bit signed range.
  always_ff @(posedge clk) begin
    if (en) begin
      if (ng_r) begin
        if (of_r || qr > {1'b0, MIN_NEG}) begin
          quo <= MIN_NEG;
        end else begin
          quo <= COORD_W'(0) - qr[QUO_W-1:0];
        end
      end else begin
        if (of_r || qr > {1'b0, MAX_POS}) begin
          quo <= MAX_POS;
        end else begin
          quo <= qr[QUO_W-1:0];
        end
      end
    end
  end

endmodule

// File: sv/affine_point_transform.sv
// Top level of the affine point transform: registers, multiply pipeline, dividers, output.
//
//   channel   direction  transfer carries
//   points    in         kind, point_x, point_y
//   results   out        result_x, result_y, degenerate
//   apb       in/out     register writes and reads, 8 bytes a register
//
// Takes one point per cycle unless the pipeline stalls; a result passes the six
// front stages, a 67-stage divider (entry, a stage per quotient bit, round, sign)
// and the output register. The divider chain is most of that depth.
// Reset (rst, synchronous) empties the pipeline and restores the identity matrix.
// A stalled output freezes the pipeline only when its last stage holds an item;
// bubbles still close up, so new points are taken while a result waits.
`timescale 1ns / 1ps

module affine_point_transform import apt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [COORD_W-1:0] pwdata,
  output logic [COORD_W-1:0] prdata,
  output logic               pready,
  apt_in_if.sink             points,
  apt_out_if.source          results
);

  logic signed [COORD_W-1:0] coef_x_from_x, coef_x_from_y, offset_x;
  logic signed [COORD_W-1:0] coef_y_from_x, coef_y_from_y, offset_y;
  logic [IDX_W-1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x_from_x <= ONE_Q;
      coef_x_from_y <= '0;
      offset_x      <= '0;
      coef_y_from_x <= '0;
      coef_y_from_y <= ONE_Q;
      offset_y      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_A:   coef_x_from_x <= pwdata;
        REG_B:   coef_x_from_y <= pwdata;
        REG_C:   offset_x      <= pwdata;
        REG_D:   coef_y_from_x <= pwdata;
        REG_E:   coef_y_from_y <= pwdata;
        REG_F:   offset_y      <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_A:   prdata = coef_x_from_x;
      REG_B:   prdata = coef_x_from_y;
      REG_C:   prdata = offset_x;
      REG_D:   prdata = coef_y_from_x;
      REG_E:   prdata = coef_y_from_y;
      REG_F:   prdata = offset_y;
      default: prdata = '0;
    endcase
  end

  // Pipeline control: shift whenever the last stage is empty or can move out.
  logic [TOTAL-1:0] vld;
  side_t            side [TOTAL];
  logic             en;
  logic             deg5;

  assign en           = !vld[TOTAL-1] || !results.valid || results.ready;
  assign points.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], points.valid};
    end
  end

  // Side data shifts along; the degenerate flag joins at the end of the front stages.
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{kind: points.kind, deg: 1'b0, px: points.point_x, py: points.point_y};
      for (int i = 1; i < TOTAL; i++) begin
        if (i == FRONT_LAT - 1) begin
          side[i] <= '{kind: side[i-1].kind, deg: deg5, px: side[i-1].px,
                       py: side[i-1].py};
        end else begin
          side[i] <= side[i-1];
        end
      end
    end
  end

  // Stage 0: operands, the point itself or its offset from the translation.
  logic signed [COORD_W:0] s0_u, s0_v;

  always_ff @(posedge clk) begin
    if (en) begin
      if (points.kind == KIND_REV) begin
        s0_u <= (COORD_W+1)'(points.point_x) - (COORD_W+1)'(offset_x);
        s0_v <= (COORD_W+1)'(points.point_y) - (COORD_W+1)'(offset_y);
      end else begin
        s0_u <= (COORD_W+1)'(points.point_x);
        s0_v <= (COORD_W+1)'(points.point_y);
      end
    end
  end

  // Six product lanes; the last two build the determinant.
  logic signed [COORD_W:0]   opa [6];
  logic signed [COORD_W-1:0] opb [6];
  logic signed [COORD_W-1:0] m1, m4;

  always_comb begin
    m1     = (side[0].kind == KIND_REV) ? coef_y_from_y : coef_x_from_x;
    m4     = (side[0].kind == KIND_REV) ? coef_x_from_x : coef_y_from_y;
    opa[0] = s0_u;
    opb[0] = m1;
    opa[1] = s0_v;
    opb[1] = coef_x_from_y;
    opa[2] = s0_u;
    opb[2] = coef_y_from_x;
    opa[3] = s0_v;
    opb[3] = m4;
    opa[4] = (COORD_W+1)'(coef_x_from_x);
    opb[4] = coef_y_from_y;
    opa[5] = (COORD_W+1)'(coef_x_from_y);
    opb[5] = coef_y_from_x;
  end

  logic signed [65:0]  pp_ll [6];
  logic signed [65:0]  pp_lh [6];
  logic signed [65:0]  pp_hl [6];
  logic signed [65:0]  pp_hh [6];
  logic signed [98:0]  lo    [6];
  logic signed [98:0]  hi    [6];
  logic signed [129:0] prod  [6];

  // Stages 1 to 3: partial products, pair sums, full product.
  for (genvar l = 0; l < 6; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        pp_ll[l] <= $signed({2'b00, opa[l][31:0]}) * $signed({2'b00, opb[l][31:0]});
        pp_lh[l] <= $signed({1'b0, opa[l][31:0]}) * $signed(opb[l][63:32]);
        pp_hl[l] <= $signed(opa[l][64:32]) * $signed({1'b0, opb[l][31:0]});
        pp_hh[l] <= $signed(opa[l][64:32]) * $signed(opb[l][63:32]);
        lo[l]    <= pp_ll[l] + (pp_lh[l] <<< 32);
        hi[l]    <= (pp_hh[l] <<< 32) + pp_hl[l];
        prod[l]  <= (hi[l] <<< 32) + lo[l];
      end
    end
  end

  // Stage 4: numerators and determinant.
  logic signed [129:0] nx4, ny4, det4;
  logic signed [129:0] ox_w, oy_w;

  assign ox_w = 130'(offset_x);
  assign oy_w = 130'(offset_y);

  always_ff @(posedge clk) begin
    if (en) begin
      if (side[3].kind == KIND_REV) begin
        nx4 <= prod[0] - prod[1];
        ny4 <= prod[3] - prod[2];
      end else begin
        nx4 <= prod[0] + prod[1] + (ox_w <<< 32);
        ny4 <= prod[2] + prod[3] + (oy_w <<< 32);
      end
      det4 <= prod[4] - prod[5];
    end
  end

  // Stage 5: magnitudes and signs for the dividers.
  logic signed [161:0] numx, numy, magx, magy;
  logic                rev4, det_neg;
  logic [NUM_W-1:0]    n5x, n5y;
  logic [DEN_W-1:0]    d5;
  logic                neg5x, neg5y;

  always_comb begin
    rev4    = side[4].kind == KIND_REV;
    det_neg = det4[129];
    numx    = rev4 ? (162'(nx4) <<< 32) : 162'(nx4);
    numy    = rev4 ? (162'(ny4) <<< 32) : 162'(ny4);
    magx    = numx[161] ? -numx : numx;
    magy    = numy[161] ? -numy : numy;
    deg5    = rev4 && (det4 == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n5x   <= NUM_W'($unsigned(magx));
      n5y   <= NUM_W'($unsigned(magy));
      d5    <= rev4 ? DEN_W'(det_neg ? -det4 : det4) : DEN_FWD;
      neg5x <= numx[161] ^ (rev4 && det_neg);
      neg5y <= numy[161] ^ (rev4 && det_neg);
    end
  end

  // Stages 6 onward: one divider per coordinate.
  logic [COORD_W-1:0] qx, qy;

  apt_div u_div_x (.clk(clk), .en(en), .num(n5x), .den(d5), .neg(neg5x), .quo(qx));
  apt_div u_div_y (.clk(clk), .en(en), .num(n5y), .den(d5), .neg(neg5y), .quo(qy));

  // Output register; a zero determinant on a reverse transfer returns the point unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (!results.valid || results.ready) begin
      results.valid <= vld[TOTAL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!results.valid || results.ready) begin
      results.result_x   <= side[TOTAL-1].deg ? side[TOTAL-1].px : qx;
      results.result_y   <= side[TOTAL-1].deg ? side[TOTAL-1].py : qy;
      results.degenerate <= side[TOTAL-1].deg;
    end
  end

  // An accepted point occupies the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready |=> vld[0])
    else $error("accepted point missing from first stage");

  // A finished item held back by the output stays in the last stage.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[TOTAL-1] && !points.ready |=> vld[TOTAL-1])
    else $error("stalled item lost from last stage");

  // Only reverse transfers can be flagged degenerate.
  a_deg: assert property (@(posedge clk) disable iff (rst)
    vld[TOTAL-1] && side[TOTAL-1].deg |-> side[TOTAL-1].kind == KIND_REV)
    else $error("degenerate flag on forward transfer");

endmodule

// File: dv/affine_point_transform_test.sv
// Self-checking testbench of the affine point transform: predicted results against the outputs.
`timescale 1ns / 1ps

module affine_point_transform_test;
  import apt_pkg::*;

  typedef logic signed [255:0] wide_t;

  // One predicted result.
  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               deg;
  } point_result_t;

  // Holds its own copy of the matrix and the results still to come.
  class transform_scoreboard;
    logic [COORD_W-1:0] mat [6];
    point_result_t      awaited [$];
    int                 errors;

    function new();
      mat[REG_A] = ONE_Q;
      mat[REG_B] = '0;
      mat[REG_C] = '0;
      mat[REG_D] = '0;
      mat[REG_E] = ONE_Q;
      mat[REG_F] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      if (idx <= REG_F) mat[idx] = val;
    endfunction

    function wide_t widen(logic [COORD_W-1:0] v);
      return {{192{v[63]}}, v};
    endfunction

    // Rounds num/den to nearest, ties away from zero, then saturates to 64 bits.
    function logic [COORD_W-1:0] round_sat(wide_t num, wide_t den);
      logic        neg;
      logic [255:0] mag, q, r;
      neg = num[255];
      mag = neg ? -num : num;
      q = mag / den;
      r = mag % den;
      if ((r << 1) >= den) q = q + 1;
      if (neg) begin
        if (q > {192'd0, MIN_NEG}) return MIN_NEG;
        return -q[63:0];
      end
      if (q > {192'd0, MAX_POS}) return MAX_POS;
      return q[63:0];
    endfunction

    function void note_point(logic kind, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
      wide_t a, b, c, d, e, f, x, y, det, dx, dy, nx, ny;
      point_result_t res;
      a = widen(mat[REG_A]); b = widen(mat[REG_B]); c = widen(mat[REG_C]);
      d = widen(mat[REG_D]); e = widen(mat[REG_E]); f = widen(mat[REG_F]);
      x = widen(px); y = widen(py);
      if (kind == KIND_FWD) begin
        nx = (c <<< 32) + a * x + b * y;
        ny = (f <<< 32) + d * x + e * y;
        res.x = round_sat(nx, wide_t'(DEN_FWD));
        res.y = round_sat(ny, wide_t'(DEN_FWD));
        res.deg = 1'b0;
      end else begin
        det = a * e - b * d;
        if (det == 0) begin
          // Singular matrix: identity fallback with the flag raised.
          res.x = px;
          res.y = py;
          res.deg = 1'b1;
        end else begin
          dx = x - c;
          dy = y - f;
          nx = (e * dx - b * dy) <<< 32;
          ny = (a * dy - d * dx) <<< 32;
          if (det[255]) begin
            det = -det;
            nx = -nx;
            ny = -ny;
          end
          res.x = round_sat(nx, det);
          res.y = round_sat(ny, det);
          res.deg = 1'b0;
        end
      end
      awaited = {awaited, res};
    endfunction

    function void check_result(logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry, logic deg);
      point_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result x %h y %h degenerate %b", $time, rx, ry, deg);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (rx !== want.x) begin
        $display("%0t: result_x expected %h actual %h", $time, want.x, rx);
        errors++;
      end
      if (ry !== want.y) begin
        $display("%0t: result_y expected %h actual %h", $time, want.y, ry);
        errors++;
      end
      if (deg !== want.deg) begin
        $display("%0t: degenerate expected %b actual %b", $time, want.deg, deg);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam logic [COORD_W-1:0] NEG_ONE_Q = 64'hFFFF_FFFF_0000_0000;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [COORD_W-1:0] pwdata;
  logic [COORD_W-1:0] prdata;
  logic               pready;

  apt_in_if  points ();
  apt_out_if results ();

  transform_scoreboard sb;
  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  int hold_left;

  affine_point_transform i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .points  (points.sink),
    .results (results.source)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop if the run hangs.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold when asked.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      results.ready <= 1'b0;
    end else begin
      results.ready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 21);
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready)
      sb.check_result(results.result_x, results.result_y, results.degenerate);
  end

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_matrix(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                              logic [COORD_W-1:0] c, logic [COORD_W-1:0] d,
                              logic [COORD_W-1:0] e, logic [COORD_W-1:0] f);
    write_reg(REG_A, a);
    write_reg(REG_B, b);
    write_reg(REG_C, c);
    write_reg(REG_D, d);
    write_reg(REG_E, e);
    write_reg(REG_F, f);
  endtask

  // Offers one point, with an occasional gap before it, and waits for the transfer.
  task automatic send_point(logic kind, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    @(negedge clk);
    if (!tx_steady && $urandom_range(99) < 21) begin
      points.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    points.valid <= 1'b1;
    points.kind <= kind;
    points.point_x <= px;
    points.point_y <= py;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    sb.note_point(kind, px, py);
  endtask

  // Lets every predicted result arrive, then the pipeline settle.
  task automatic drain();
    @(negedge clk);
    points.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (TOTAL + 6) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sign-extended value of about the given number of bits.
  function automatic logic [COORD_W-1:0] rand_narrow(int bits);
    logic [COORD_W-1:0] v;
    v = rand64();
    return COORD_W'($signed(v << (64 - bits)) >>> (64 - bits));
  endfunction

  function automatic logic [COORD_W-1:0] rand_point();
    case ($urandom_range(3))
      0: return rand64();
      1: return rand_narrow(48);
      2: return rand_narrow(36);
      default: begin
        case ($urandom_range(4))
          0: return MAX_POS;
          1: return MIN_NEG;
          2: return ONE_Q;
          3: return NEG_ONE_Q;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_extreme();
    case ($urandom_range(5))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return '0;
      3: return ONE_Q;
      4: return NEG_ONE_Q;
      default: return rand64();
    endcase
  endfunction

  // Picks a matrix whose style depends on the phase.
  task automatic random_matrix(int style);
    logic [COORD_W-1:0] a, d, m;
    case (style)
      0: write_matrix(rand_narrow(36), rand_narrow(36), rand_narrow(48),
                      rand_narrow(36), rand_narrow(36), rand_narrow(48));
      1: write_matrix(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      2: begin
        // Second column a multiple of the first: zero determinant.
        a = rand_narrow(34);
        d = rand_narrow(34);
        m = COORD_W'($urandom_range(1, 7));
        if ($urandom_range(1)) m = -m;
        write_matrix(a, a * m, rand_narrow(48), d, d * m, rand_narrow(48));
      end
      default: write_matrix(pick_extreme(), pick_extreme(), pick_extreme(),
                            pick_extreme(), pick_extreme(), pick_extreme());
    endcase
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    points.valid = 1'b0;
    points.kind = KIND_FWD;
    points.point_x = '0;
    points.point_y = '0;
    results.ready = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity matrix after reset, extreme points both ways.
    send_point(KIND_FWD, '0, '0);
    send_point(KIND_FWD, MAX_POS, MIN_NEG);
    send_point(KIND_REV, MIN_NEG, MAX_POS);
    send_point(KIND_REV, ONE_Q, NEG_ONE_Q);
    drain();

    // Half scales make rounding ties; an unused register index must be ignored.
    write_matrix(64'h0000_0000_8000_0000, '0, '0, '0, 64'hFFFF_FFFF_8000_0000, '0);
    write_reg(REG_UNUSED, rand64());
    send_point(KIND_FWD, 64'd1, 64'd1);
    send_point(KIND_FWD, -64'sd1, -64'sd1);
    send_point(KIND_FWD, 64'd3, -64'sd3);
    send_point(KIND_REV, 64'd1, -64'sd1);
    send_point(KIND_REV, MAX_POS, MIN_NEG);
    drain();

    // Singular matrix: reverse returns the point with the flag.
    write_matrix(ONE_Q, ONE_Q, ONE_Q, ONE_Q << 1, ONE_Q << 1, NEG_ONE_Q);
    send_point(KIND_REV, 64'h1234_5678_9ABC_DEF0, MIN_NEG);
    send_point(KIND_FWD, ONE_Q, ONE_Q);
    send_point(KIND_REV, MAX_POS, '0);
    drain();

    // Saturation at both ends.
    write_matrix(MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
    send_point(KIND_FWD, MAX_POS, MAX_POS);
    send_point(KIND_FWD, MIN_NEG, MIN_NEG);
    send_point(KIND_REV, MAX_POS, MIN_NEG);
    drain();
    write_matrix(MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG);
    send_point(KIND_FWD, MIN_NEG, MAX_POS);
    send_point(KIND_REV, MIN_NEG, MIN_NEG);
    drain();
    write_reg(REG_UNUSED, '0);
    write_matrix(-64'sd1, 64'd1, '0, 64'd1, 64'd1, '0);
    send_point(KIND_REV, MAX_POS, MAX_POS);
    send_point(KIND_REV, '0, 64'd5);
    drain();

    // Random phases over several matrix styles.
    for (int phase = 0; phase < 8; phase++) begin
      random_matrix(phase % 4);
      tx_steady = (phase == 6);
      rx_steady = (phase == 6);
      for (int n = 0; n < 240; n++) begin
        send_point(logic'($urandom_range(1)), rand_point(), rand_point());
        if (phase == 2 && n == 20) hold_req = 1'b1;
        if (phase == 4 && n == 120) begin
          @(negedge clk);
          points.valid <= 1'b0;
          while (sb.pending() > 0) @(posedge clk);
        end
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/apt_pkg.sv
sv/apt_if.sv
sv/apt_div.sv
sv/affine_point_transform.sv
dv/affine_point_transform_test.sv
